FILE: sv/smrq_pkg.sv
// Shared types and constants for the sorted message retransmit queue.
// Used by smrq_cell and sorted_message_retransmit_queue; no dependencies.
package smrq_pkg;

    localparam int CAPACITY          = 10;
    localparam int MAX_PAYLOAD_BYTES = 8;
    localparam int CNT_W             = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_PUSH_ACK     = 3'd0,
        OP_INSERT_NEW   = 3'd1,
        OP_INSERT_GIVEN = 3'd2,
        OP_PURGE        = 3'd3,
        OP_QUERY        = 3'd4,
        OP_POP          = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_DROP_ACK
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PURGE
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  serial;
        logic [3:0]  length;
        logic [63:0] payload;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        logic     force_head;
        entry_t   new_entry;
    } cell_ctrl_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic        msg_kind;
        logic [7:0]  msg_serial;
        logic [3:0]  msg_length;
        logic [63:0] msg_payload;
        logic [3:0]  query_index;
    } cmd_t;

    typedef struct packed {
        logic        success;
        logic [3:0]  entry_count;
        logic        out_kind;
        logic [7:0]  out_serial;
        logic [3:0]  out_length;
        logic [63:0] out_payload;
    } rsp_t;

endpackage

FILE: sv/smrq_cell.sv
// One slot of the ordered store; shifts toward either neighbor or takes a new entry.
// Depends on smrq_pkg for the entry and control types.
module smrq_cell (
    input  logic                clk,
    input  smrq_pkg::cell_ctrl_t ctrl,
    input  logic                active,
    input  logic                at_tail,
    input  smrq_pkg::entry_t    left,
    input  smrq_pkg::entry_t    right,
    input  logic                hit_in,
    output logic                hit_out,
    output smrq_pkg::entry_t    entry
);

    smrq_pkg::entry_t entry_reg;
    smrq_pkg::entry_t entry_next;
    logic             hit;

    always_comb
    begin
        hit = 1'b0;
        case (ctrl.op)
            smrq_pkg::CELL_INSERT:
                hit = active && (ctrl.force_head || (entry_reg.serial < ctrl.new_entry.serial));
            smrq_pkg::CELL_DROP_ACK:
                hit = active && entry_reg.kind;
            default:
                hit = 1'b0;
        endcase
        hit_out = hit_in || hit;
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            smrq_pkg::CELL_INSERT:
            begin
                // everything past the insertion point moves one slot toward the tail
                if (hit_in)
                    entry_next = left;
                else if (hit || at_tail)
                    entry_next = ctrl.new_entry;
            end
            smrq_pkg::CELL_POP:
                entry_next = right;
            smrq_pkg::CELL_DROP_ACK:
            begin
                if (hit_in || hit)
                    entry_next = right;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: sv/sorted_message_retransmit_queue.sv
// Top level of the sorted message retransmit queue: control, counters and the row of cells.
// Depends on smrq_pkg and smrq_cell.
//
// Usage:
//   A request enters on cmd (cmd_valid/cmd_ready) and exactly one response
//   leaves on rsp (rsp_valid/rsp_ready), in request order.
//   The store is a row of CAPACITY cells; inserts, pushes and pops move
//   every cell at once, with the insertion point found by a ripple of
//   compare flags along the row.
//   For push, inserts, query and pop the request is registered at acceptance;
//   the row and the response register update in the execute step, once the
//   response register is free. Purge removes one acknowledgement per cycle
//   and loads its response once none is left and the response register is free.
//   cmd_ready is high only while no request is in progress, so a new request
//   is not taken before the last one has left its execute or purge step.
//   A finished response waits in its register while the next request is
//   taken; if rsp_ready stays low, the following request holds in its
//   execute step until the response register frees up.
//   Reset clears the entry count, the serial counter, rsp_valid and the control
//   state; slot contents are not cleared and are only ever read below the count.
module sorted_message_retransmit_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  smrq_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output smrq_pkg::rsp_t rsp
);

    localparam int CNT_W = smrq_pkg::CNT_W;
    localparam int CAP   = smrq_pkg::CAPACITY;

    smrq_pkg::state_t     state_reg;
    smrq_pkg::state_t     state_next;
    smrq_pkg::cmd_t       req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [7:0]           serial_reg;
    logic [7:0]           serial_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    smrq_pkg::rsp_t       rsp_reg;
    smrq_pkg::rsp_t       rsp_next;

    smrq_pkg::cell_ctrl_t ctrl;
    smrq_pkg::cell_op_t   cell_op;
    smrq_pkg::entry_t     cell_q [CAP];
    logic [CAP:0]         hit_chain;
    logic [CAP-1:0]       active;
    logic [CAP-1:0]       at_tail;

    smrq_pkg::op_t        op;
    logic                 is_known;
    logic                 full;
    logic                 empty;
    logic                 out_free;
    logic                 query_ok;
    logic [3:0]           len_sat;
    logic [63:0]          byte_mask;
    smrq_pkg::entry_t     query_entry;
    logic                 rsp_load;

    assign op       = smrq_pkg::op_t'(req_reg.operation);
    assign is_known = (req_reg.operation <= 3'(smrq_pkg::OP_POP));
    assign full     = (count_reg == CNT_W'(CAP));
    assign empty    = (count_reg == '0);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign query_ok = (8'(req_reg.query_index) < 8'(count_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smrq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = smrq_pkg::ST_EXEC;
            end
            smrq_pkg::ST_EXEC:
            begin
                if (is_known && (op == smrq_pkg::OP_PURGE))
                    state_next = smrq_pkg::ST_PURGE;
                else if (out_free)
                    state_next = smrq_pkg::ST_IDLE;
            end
            smrq_pkg::ST_PURGE:
            begin
                if (!hit_chain[CAP] && out_free)
                    state_next = smrq_pkg::ST_IDLE;
            end
            default:
                state_next = smrq_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        cmd_ready = 1'b0;
        cell_op   = smrq_pkg::CELL_HOLD;
        rsp_load  = 1'b0;
        unique case (state_reg)
            smrq_pkg::ST_IDLE:
                cmd_ready = 1'b1;
            smrq_pkg::ST_EXEC:
            begin
                if (out_free && is_known && (op != smrq_pkg::OP_PURGE))
                begin
                    rsp_load = 1'b1;
                    case (op)
                        smrq_pkg::OP_PUSH_ACK, smrq_pkg::OP_INSERT_NEW,
                        smrq_pkg::OP_INSERT_GIVEN:
                            cell_op = full ? smrq_pkg::CELL_HOLD : smrq_pkg::CELL_INSERT;
                        smrq_pkg::OP_POP:
                            cell_op = empty ? smrq_pkg::CELL_HOLD : smrq_pkg::CELL_POP;
                        default:
                            cell_op = smrq_pkg::CELL_HOLD;
                    endcase
                end
                else if (out_free && !is_known)
                    rsp_load = 1'b1;
            end
            smrq_pkg::ST_PURGE:
            begin
                cell_op  = smrq_pkg::CELL_DROP_ACK;
                rsp_load = !hit_chain[CAP] && out_free;
            end
            default:
                cmd_ready = 1'b0;
        endcase
    end

    // new entry for the row
    always_comb
    begin
        len_sat = (req_reg.msg_length > 4'(smrq_pkg::MAX_PAYLOAD_BYTES))
                  ? 4'(smrq_pkg::MAX_PAYLOAD_BYTES) : req_reg.msg_length;
        for (int b = 0; b < 8; b++)
            byte_mask[8*b +: 8] = {8{(4'(b) < len_sat)}};

        ctrl.op         = cell_op;
        ctrl.force_head = (op == smrq_pkg::OP_PUSH_ACK);
        ctrl.new_entry.kind    = req_reg.msg_kind;
        ctrl.new_entry.serial  = req_reg.msg_serial;
        ctrl.new_entry.length  = len_sat;
        ctrl.new_entry.payload = req_reg.msg_payload & byte_mask;
        case (op)
            smrq_pkg::OP_PUSH_ACK:
            begin
                ctrl.new_entry.kind    = 1'b1;
                ctrl.new_entry.serial  = 8'd0;
                ctrl.new_entry.length  = 4'd1;
                ctrl.new_entry.payload = {56'd0, req_reg.msg_serial};
            end
            smrq_pkg::OP_INSERT_NEW:
            begin
                ctrl.new_entry.kind   = 1'b0;
                ctrl.new_entry.serial = serial_reg;
            end
            default:
                ctrl.new_entry.kind = req_reg.msg_kind;
        endcase
    end

    // query select
    always_comb
    begin
        query_entry = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if (8'(req_reg.query_index) == 8'(i))
                query_entry = cell_q[i];
        end
    end

    // counters and response
    always_comb
    begin
        count_next  = count_reg;
        serial_next = serial_reg;
        case (ctrl.op)
            smrq_pkg::CELL_INSERT:
            begin
                count_next = count_reg + CNT_W'(1);
                if (op == smrq_pkg::OP_INSERT_NEW)
                    serial_next = serial_reg + 8'd1;
            end
            smrq_pkg::CELL_POP:
                count_next = count_reg - CNT_W'(1);
            smrq_pkg::CELL_DROP_ACK:
            begin
                if (hit_chain[CAP])
                    count_next = count_reg - CNT_W'(1);
            end
            default:
                count_next = count_reg;
        endcase

        rsp_next             = '0;
        rsp_next.entry_count = 4'(count_next);
        if (is_known)
        begin
            case (op)
                smrq_pkg::OP_PUSH_ACK, smrq_pkg::OP_INSERT_NEW, smrq_pkg::OP_INSERT_GIVEN:
                    rsp_next.success = !full;
                smrq_pkg::OP_PURGE:
                    rsp_next.success = 1'b1;
                smrq_pkg::OP_QUERY:
                begin
                    if (query_ok)
                    begin
                        rsp_next.success     = 1'b1;
                        rsp_next.out_kind    = query_entry.kind;
                        rsp_next.out_serial  = query_entry.serial;
                        rsp_next.out_length  = query_entry.length;
                        rsp_next.out_payload = query_entry.payload;
                    end
                end
                smrq_pkg::OP_POP:
                begin
                    if (!empty)
                    begin
                        rsp_next.success     = 1'b1;
                        rsp_next.out_kind    = cell_q[0].kind;
                        rsp_next.out_serial  = cell_q[0].serial;
                        rsp_next.out_length  = cell_q[0].length;
                        rsp_next.out_payload = cell_q[0].payload;
                    end
                end
                default:
                    rsp_next.success = 1'b0;
            endcase
        end

        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
            rsp_valid_next = 1'b0;
        if (rsp_load)
            rsp_valid_next = 1'b1;
    end

    // row of cells
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        assign active[i]  = (CNT_W'(i) < count_reg);
        assign at_tail[i] = (CNT_W'(i) == count_reg);

        smrq_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .active  (active[i]),
            .at_tail (at_tail[i]),
            .left    ((i == 0) ? ctrl.new_entry : cell_q[(i == 0) ? 0 : i - 1]),
            .right   ((i == CAP - 1) ? cell_q[i] : cell_q[(i == CAP - 1) ? i : i + 1]),
            .hit_in  (hit_chain[i]),
            .hit_out (hit_chain[i+1]),
            .entry   (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smrq_pkg::ST_IDLE;
            count_reg     <= '0;
            serial_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            serial_reg    <= serial_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            req_reg <= cmd;
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
